[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define BRBR_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define BRBR_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define BRBR_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg)
`define BRBR_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

[hw/rtl/brbr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package brbr_pkg;

  localparam int INDEX_BITS  = 40;
  localparam int OFFSET_BITS = 48;

  localparam int BS_W    = 25;
  localparam int BPF_W   = 16;
  localparam int FSIZE_W = 48;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;

  localparam logic [1:0] REG_BLOCK_SIZE  = 2'd0;
  localparam logic [1:0] REG_FETCH_LIMIT = 2'd1;
  localparam logic [1:0] REG_FILE_SIZE   = 2'd2;

  localparam logic [BS_W-1:0]    BS_RESET    = BS_W'(65536);
  localparam logic [BPF_W-1:0]   BPF_RESET   = BPF_W'(16);
  localparam logic [FSIZE_W-1:0] FSIZE_RESET = '0;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  // multiplier split: operand is an index or index+1, cut into two halves
  localparam int OP_W     = INDEX_BITS + 1;
  localparam int LO_W     = OP_W / 2;
  localparam int HI_W     = OP_W - LO_W;
  localparam int PP_LO_W  = LO_W + BS_W;
  localparam int PP_HI_W  = HI_W + BS_W;
  localparam int PROD_W   = OP_W + BS_W;
  localparam int SUM_W    = (PROD_W > OFFSET_BITS) ? PROD_W : OFFSET_BITS + 1;
  localparam int CMP_W    = (OFFSET_BITS > FSIZE_W) ? OFFSET_BITS : FSIZE_W;

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

  typedef struct packed {
    logic [BS_W-1:0]    block_size;
    logic [BPF_W-1:0]   fetch_limit;
    logic [FSIZE_W-1:0] file_size;
  } cfg_t;

  // one or two ranges; the second one is always the final range
  typedef struct packed {
    logic [INDEX_BITS-1:0] first0;
    logic [INDEX_BITS-1:0] last0;
    logic                  fin0;
    logic                  two;
    logic [INDEX_BITS-1:0] first1;
    logic [INDEX_BITS-1:0] last1;
  } range_cmd_t;

endpackage
`default_nettype wire

[hw/rtl/brbr_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface brbr_in_if import brbr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] block_index;
  logic                  last_block;

  modport source (output valid, output block_index, output last_block, input ready);
  modport sink   (input valid, input block_index, input last_block, output ready);
endinterface
`default_nettype wire

[hw/rtl/brbr_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface brbr_out_if import brbr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OFFSET_BITS-1:0] range_begin;
  logic [OFFSET_BITS-1:0] range_end;
  logic                   last_range;

  modport source (output valid, output range_begin, output range_end, output last_range,
                  input ready);
  modport sink   (input valid, input range_begin, input range_end, input last_range,
                  output ready);
endinterface
`default_nettype wire

[hw/rtl/brbr_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none
module brbr_cfg import brbr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t       cfg_r, cfg_nxt;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:3];
  assign wr_en   = psel & penable & pwrite;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_BLOCK_SIZE:  cfg_nxt.block_size  = pwdata[BS_W-1:0];
        REG_FETCH_LIMIT: cfg_nxt.fetch_limit = pwdata[BPF_W-1:0];
        REG_FILE_SIZE:   cfg_nxt.file_size   = pwdata[FSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BLOCK_SIZE:  prdata = CFG_DATA_W'(cfg_r.block_size);
      REG_FETCH_LIMIT: prdata = CFG_DATA_W'(cfg_r.fetch_limit);
      REG_FILE_SIZE:   prdata = CFG_DATA_W'(cfg_r.file_size);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_size  <= BS_RESET;
      cfg_r.fetch_limit <= BPF_RESET;
      cfg_r.file_size   <= FSIZE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/brbr_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module brbr_front import brbr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  brbr_in_if.sink          in_chan,
  input  logic [BPF_W-1:0] fetch_limit,
  input  logic             push_ready,
  output logic             push_valid,
  output range_cmd_t       push_cmd
);

  logic [INDEX_BITS-1:0] run_first_r, run_first_nxt;
  logic [INDEX_BITS-1:0] run_last_r, run_last_nxt;
  logic [BPF_W-1:0]      run_length_r, run_length_nxt;
  logic                  run_open_r, run_open_nxt;

  logic                  accept;
  logic [INDEX_BITS-1:0] x;
  logic                  fin;
  logic [BPF_W-1:0]      limit;
  logic [OP_W-1:0]       succ;
  logic                  merge;
  logic                  close_prev;

  assign in_chan.ready = push_ready;
  assign accept        = in_chan.valid & push_ready;
  assign x             = in_chan.block_index;
  assign fin           = in_chan.last_block;

  assign limit      = (fetch_limit == '0) ? BPF_W'(1) : fetch_limit;
  assign succ       = {1'b0, run_last_r} + OP_W'(1);
  assign merge      = run_open_r && ({1'b0, x} == succ) && (run_length_r < limit);
  assign close_prev = run_open_r && !merge;
  assign push_valid = accept && (close_prev || fin);

  always_comb begin
    push_cmd.first1 = x;
    push_cmd.last1  = x;
    if (close_prev) begin
      push_cmd.first0 = run_first_r;
      push_cmd.last0  = run_last_r;
      push_cmd.fin0   = 1'b0;
      push_cmd.two    = fin;
    end else begin
      push_cmd.first0 = merge ? run_first_r : x;
      push_cmd.last0  = x;
      push_cmd.fin0   = 1'b1;
      push_cmd.two    = 1'b0;
    end
  end

  always_comb begin
    run_first_nxt  = run_first_r;
    run_last_nxt   = run_last_r;
    run_length_nxt = run_length_r;
    run_open_nxt   = run_open_r;
    if (accept) begin
      if (fin) begin
        run_first_nxt  = '0;
        run_last_nxt   = '0;
        run_length_nxt = '0;
        run_open_nxt   = 1'b0;
      end else if (merge) begin
        run_last_nxt   = x;
        run_length_nxt = run_length_r + BPF_W'(1);
      end else begin
        run_first_nxt  = x;
        run_last_nxt   = x;
        run_length_nxt = BPF_W'(1);
        run_open_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_first_r  <= '0;
      run_last_r   <= '0;
      run_length_r <= '0;
      run_open_r   <= 1'b0;
    end else begin
      run_first_r  <= run_first_nxt;
      run_last_r   <= run_last_nxt;
      run_length_r <= run_length_nxt;
      run_open_r   <= run_open_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/brbr_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module brbr_fifo import brbr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  input  range_cmd_t push_cmd,
  output logic       push_ready,
  output logic       pop_valid,
  output range_cmd_t pop_cmd,
  input  logic       pop_ready
);

  range_cmd_t            mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = (count_r != FIFO_CNT_W'(FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_ready & pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + FIFO_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + FIFO_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + FIFO_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  `BRBR_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, count_r <= FIFO_CNT_W'(FIFO_DEPTH), "queue count beyond depth")
  `BRBR_ASSERT_IMPL(a_ptr_track, clk, rst_n, 1'b1, (wr_ptr_r - rd_ptr_r) == count_r[FIFO_PTR_W-1:0], "queue pointers disagree with count")
  `BRBR_ASSERT_NEXT(a_cnt_inc, clk, rst_n, do_push && !do_pop, count_r == $past(count_r) + FIFO_CNT_W'(1), "queue count missed a push")

endmodule
`default_nettype wire

[hw/rtl/brbr_back.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module brbr_back import brbr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       pop_valid,
  input  range_cmd_t pop_cmd,
  output logic       pop_ready,
  brbr_out_if.source out_chan
);

  logic                  phase_r, phase_nxt;
  logic                  advance;
  logic                  issue;
  logic [INDEX_BITS-1:0] sel_first;
  logic [INDEX_BITS-1:0] sel_last;
  logic                  sel_fin;
  logic [OP_W-1:0]       op_beg;
  logic [OP_W-1:0]       op_end;
  logic [BS_W-1:0]       bs;

  logic                  v1_r, fin1_r;
  logic [PP_LO_W-1:0]    pb_lo_r, pe_lo_r;
  logic [PP_HI_W-1:0]    pb_hi_r, pe_hi_r;

  logic                  v2_r, fin2_r;
  logic [SUM_W-1:0]      prod_b_r, prod_e_r;

  logic                   out_valid_r;
  logic [OFFSET_BITS-1:0] out_begin_r, out_end_r;
  logic                   out_last_r;

  logic                   sat_b, sat_e;
  logic [OFFSET_BITS-1:0] beg_val;
  logic [OFFSET_BITS-1:0] end_raw;
  logic [OFFSET_BITS-1:0] end_val;
  logic [CMP_W-1:0]       fs_m1;

  // whole pipeline moves together; output register acts as the skid stage
  assign advance   = !out_valid_r || out_chan.ready;
  assign issue     = advance && pop_valid;
  assign pop_ready = issue && (phase_r || !pop_cmd.two);
  assign phase_nxt = issue ? (!phase_r && pop_cmd.two) : phase_r;

  assign sel_first = phase_r ? pop_cmd.first1 : pop_cmd.first0;
  assign sel_last  = phase_r ? pop_cmd.last1 : pop_cmd.last0;
  assign sel_fin   = phase_r ? 1'b1 : pop_cmd.fin0;
  assign op_beg    = {1'b0, sel_first};
  assign op_end    = {1'b0, sel_last} + OP_W'(1);
  assign bs        = (cfg.block_size == '0) ? BS_W'(1) : cfg.block_size;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (advance) begin
        v1_r        <= issue;
        v2_r        <= v1_r;
        out_valid_r <= v2_r;
      end
    end
  end

  // stage 1: partial products of both operands
  always_ff @(posedge clk) begin
    if (advance) begin
      fin1_r  <= sel_fin;
      pb_lo_r <= {{BS_W{1'b0}}, op_beg[LO_W-1:0]} * {{LO_W{1'b0}}, bs};
      pb_hi_r <= {{BS_W{1'b0}}, op_beg[OP_W-1:LO_W]} * {{HI_W{1'b0}}, bs};
      pe_lo_r <= {{BS_W{1'b0}}, op_end[LO_W-1:0]} * {{LO_W{1'b0}}, bs};
      pe_hi_r <= {{BS_W{1'b0}}, op_end[OP_W-1:LO_W]} * {{HI_W{1'b0}}, bs};
    end
  end

  // stage 2: recombine
  always_ff @(posedge clk) begin
    if (advance) begin
      fin2_r   <= fin1_r;
      prod_b_r <= SUM_W'(pb_lo_r) + (SUM_W'(pb_hi_r) << LO_W);
      prod_e_r <= SUM_W'(pe_lo_r) + (SUM_W'(pe_hi_r) << LO_W);
    end
  end

  // stage 3: saturate, make inclusive, clip at file end
  always_comb begin
    sat_b   = |prod_b_r[SUM_W-1:OFFSET_BITS];
    sat_e   = |prod_e_r[SUM_W-1:OFFSET_BITS];
    beg_val = sat_b ? OFFSET_MAX : prod_b_r[OFFSET_BITS-1:0];
    end_raw = sat_e ? OFFSET_MAX : prod_e_r[OFFSET_BITS-1:0] - OFFSET_BITS'(1);
    fs_m1   = CMP_W'(cfg.file_size) - CMP_W'(1);
    end_val = end_raw;
    if ((cfg.file_size != '0) && (CMP_W'(end_raw) > fs_m1)) begin
      end_val = fs_m1[OFFSET_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_begin_r <= beg_val;
      out_end_r   <= end_val;
      out_last_r  <= fin2_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.range_begin = out_begin_r;
  assign out_chan.range_end   = out_end_r;
  assign out_chan.last_range  = out_last_r;

  `BRBR_ASSERT_IMPL(a_phase_head, clk, rst_n, phase_r, pop_valid && pop_cmd.two, "second range issued without a paired command")

endmodule
`default_nettype wire

[hw/rtl/block_run_to_byte_range_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Block run to byte range unit.
// in_chan carries one missing block index per beat, ascending, with last_block on the
// final index. out_chan carries inclusive byte ranges, last_range on the final one.
// Consecutive indices merge into runs of up to fetch_limit blocks.
// The APB port holds block_size (0x00), fetch_limit (0x08) and file_size (0x10),
// 64-bit data; pready is tied high. Write only while idle.
// Throughput: one index per cycle while the command queue has room. Each range takes one
// slot of the shared three-stage multiply pipeline, so an index that closes a run and is
// also final issues two ranges into the back end.
// A range passes through the command queue, stage 1, stage 2 and the output register after
// the index that closes it is accepted; the second range of such a final index follows it.
// A four-entry command queue between run tracking and the range pipeline absorbs
// bursts; when out_chan stalls the pipeline holds, the queue fills and in_chan.ready
// falls once four commands wait.
// Reset (synchronous, rst_n low) closes any open run, empties the queue and pipeline and
// restores block_size 65536, fetch_limit 16, file_size 0. No clearing pass.
module block_run_to_byte_range_unit import brbr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  brbr_in_if.sink               in_chan,
  brbr_out_if.source            out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t       cfg;
  logic       push_valid, push_ready;
  range_cmd_t push_cmd;
  logic       pop_valid, pop_ready;
  range_cmd_t pop_cmd;

  brbr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  brbr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .fetch_limit (cfg.fetch_limit),
    .push_ready  (push_ready),
    .push_valid  (push_valid),
    .push_cmd    (push_cmd)
  );

  brbr_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  brbr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .pop_ready (pop_ready),
    .out_chan  (out_chan)
  );

endmodule
`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps
module tb import brbr_pkg::*; ();

  localparam int QUIET_CYCLES     = 8;
  localparam int WATCHDOG_LIMIT   = 20000;
  localparam int PHASE_ITEMS      = 190;
  localparam int RANDOM_PHASES    = 8;
  localparam int HOLD_CYCLES      = 400;
  localparam logic [INDEX_BITS-1:0] TOP_INDEX = {INDEX_BITS{1'b1}};

  typedef struct packed {
    logic [OFFSET_BITS-1:0] rbegin;
    logic [OFFSET_BITS-1:0] rend;
    logic                   fin;
  } byte_span_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  brbr_in_if  in_chan();
  brbr_out_if out_chan();

  block_run_to_byte_range_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor copy of the registers and run state
  logic [BS_W-1:0]       cfg_bs  = BS_RESET;
  logic [BPF_W-1:0]      cfg_bpf = BPF_RESET;
  logic [FSIZE_W-1:0]    cfg_fsz = FSIZE_RESET;
  logic [INDEX_BITS-1:0] run_head;
  logic [INDEX_BITS-1:0] run_tail;
  logic [BPF_W-1:0]      run_count;
  bit                    run_active;

  byte_span_t pending_spans[$];
  byte_span_t due_span;

  int  mismatches;
  int  items_sent;
  int  spans_seen;
  int  cfg_writes;
  int  idle_cycles;
  bit  tx_random;
  bit  rx_random;
  int  hold_request;
  int  rx_left;

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 80);
  endfunction

  function automatic int sender_gap();
    if (!tx_random || $urandom_range(0, 99) < 70) return 0;
    return gap_len();
  endfunction

  function automatic logic [OFFSET_BITS-1:0] sat_offset(input logic [65:0] prod);
    return (prod > 66'(OFFSET_MAX)) ? OFFSET_MAX : prod[OFFSET_BITS-1:0];
  endfunction

  function automatic byte_span_t span_of(input logic [INDEX_BITS-1:0] head,
                                         input logic [INDEX_BITS-1:0] tail,
                                         input bit fin);
    logic [BS_W-1:0]        bs;
    logic [65:0]            prod;
    logic [OFFSET_BITS-1:0] stop;
    byte_span_t             s;
    bs = (cfg_bs == '0) ? BS_W'(1) : cfg_bs;
    s.rbegin = sat_offset(66'(head) * 66'(bs));
    prod = (66'(tail) + 66'd1) * 66'(bs);
    stop = (prod > 66'(OFFSET_MAX)) ? OFFSET_MAX : prod[OFFSET_BITS-1:0] - 1'b1;
    if (cfg_fsz != '0 && stop > cfg_fsz - 1'b1) stop = cfg_fsz - 1'b1;
    s.rend = stop;
    s.fin  = fin;
    return s;
  endfunction

  task automatic coalesce_index(input logic [INDEX_BITS-1:0] idx, input bit fin);
    logic [BPF_W-1:0] cap;
    cap = (cfg_bpf == '0) ? BPF_W'(1) : cfg_bpf;
    if (run_active && {1'b0, idx} == {1'b0, run_tail} + 1'b1 && run_count < cap) begin
      run_tail  = idx;
      run_count = run_count + 1'b1;
    end else begin
      if (run_active)
        pending_spans.insert(pending_spans.size(), span_of(run_head, run_tail, 1'b0));
      run_head   = idx;
      run_tail   = idx;
      run_count  = BPF_W'(1);
      run_active = 1'b1;
    end
    if (fin) begin
      pending_spans.insert(pending_spans.size(), span_of(run_head, run_tail, 1'b1));
      run_head   = '0;
      run_tail   = '0;
      run_count  = '0;
      run_active = 1'b0;
    end
  endtask

  task automatic offer_index(input logic [INDEX_BITS-1:0] idx, input bit fin);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_chan.valid       <= 1'b1;
    in_chan.block_index <= idx;
    in_chan.last_block  <= fin;
    do @(posedge clk); while (!(in_chan.valid && in_chan.ready));
    coalesce_index(idx, fin);
    items_sent++;
  endtask

  task automatic await_quiet();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] sel, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({sel, 3'b000});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (sel)
      REG_BLOCK_SIZE:  cfg_bs  = value[BS_W-1:0];
      REG_FETCH_LIMIT: cfg_bpf = value[BPF_W-1:0];
      REG_FILE_SIZE:   cfg_fsz = value[FSIZE_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] bs, input logic [CFG_DATA_W-1:0] bpf,
                            input logic [CFG_DATA_W-1:0] fsz);
    write_reg(REG_BLOCK_SIZE, bs);
    write_reg(REG_FETCH_LIMIT, bpf);
    write_reg(REG_FILE_SIZE, fsz);
  endtask

  task automatic note_mismatch(input string what, input byte_span_t want);
    if (mismatches < 10)
      $display("%0t %s: expected begin %h end %h last %0b, got begin %h end %h last %0b",
               $realtime, what, want.rbegin, want.rend, want.fin,
               out_chan.range_begin, out_chan.range_end, out_chan.last_range);
    mismatches++;
  endtask

  // range checker
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      spans_seen++;
      if (pending_spans.size() == 0) begin
        note_mismatch("unexpected range", '0);
      end else begin
        due_span = pending_spans.pop_front();
        if (out_chan.range_begin !== due_span.rbegin || out_chan.range_end !== due_span.rend ||
            out_chan.last_range !== due_span.fin)
          note_mismatch("range", due_span);
      end
    end
  end

  // range receiver
  always @(negedge clk) begin
    if (hold_request > 0) begin
      rx_left = hold_request - 1;
      hold_request = 0;
      out_chan.ready <= 1'b0;
    end else if (rx_left > 0) begin
      rx_left--;
      out_chan.ready <= 1'b0;
    end else if (rx_random && $urandom_range(0, 99) < 25) begin
      rx_left = gap_len() - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d ranges outstanding",
                 idle_cycles, pending_spans.size());
        $display("block_run_to_byte_range_unit: mismatch");
        $finish;
      end
    end
  end

  task automatic test_reset_settings();
    tx_random = 1'b0;
    rx_random = 1'b0;
    offer_index(40'd0, 1'b0);
    offer_index(40'd1, 1'b0);
    offer_index(40'd2, 1'b1);
    offer_index(TOP_INDEX, 1'b1);
    offer_index(TOP_INDEX, 1'b0);
    offer_index(40'd0, 1'b1);
    offer_index(40'd5, 1'b0);
    offer_index(40'd5, 1'b0);
    offer_index(40'd4, 1'b1);
    await_quiet();
  endtask

  task automatic test_zero_registers();
    set_config(64'd0, 64'd0, 64'd0);
    offer_index(40'd7, 1'b0);
    offer_index(40'd8, 1'b0);
    offer_index(40'd9, 1'b1);
    await_quiet();
  endtask

  task automatic test_file_end_clip();
    set_config(64'd64, 64'd4, 64'd100);
    offer_index(40'd1, 1'b0);
    offer_index(40'd2, 1'b1);
    offer_index(40'd3, 1'b1);
    await_quiet();
    write_reg(REG_FILE_SIZE, 64'(OFFSET_MAX));
    offer_index(40'd0, 1'b1);
    await_quiet();
  endtask

  task automatic test_wide_values();
    set_config(64'h1FF_FFFF, 64'hFFFF, 64'd0);
    offer_index(TOP_INDEX - 2, 1'b0);
    offer_index(TOP_INDEX - 1, 1'b0);
    offer_index(TOP_INDEX, 1'b1);
    offer_index(40'd0, 1'b0);
    offer_index(40'd1, 1'b1);
    await_quiet();
  endtask

  // every index breaks the run, so the queue fills while the sink holds off
  task automatic test_backpressure();
    int k;
    set_config(64'd4096, 64'd2, 64'd0);
    tx_random = 1'b0;
    rx_random = 1'b0;
    hold_request = HOLD_CYCLES;
    @(negedge clk);
    for (k = 0; k < 40; k++)
      offer_index(INDEX_BITS'(10 * k), k == 39);
    await_quiet();
  endtask

  task automatic send_run_list(input int len);
    logic [INDEX_BITS-1:0] idx;
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r < 45)      idx = INDEX_BITS'($urandom_range(0, 4095));
    else if (r < 90) idx = INDEX_BITS'({$urandom, $urandom});
    else             idx = TOP_INDEX - INDEX_BITS'($urandom_range(0, 20));
    for (k = 0; k < len; k++) begin
      offer_index(idx, k == len - 1);
      r = $urandom_range(0, 99);
      if (r < 72)      idx = idx + 1'b1;
      else if (r < 86) idx = idx + INDEX_BITS'($urandom_range(2, 6));
      else if (r < 91) idx = idx;
      else if (r < 95) idx = idx - INDEX_BITS'($urandom_range(1, 3));
      else             idx = INDEX_BITS'({$urandom, $urandom});
    end
  endtask

  task automatic test_random_lists();
    int ph;
    int start;
    int r;
    logic [CFG_DATA_W-1:0] fsz;
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      r = $urandom_range(0, 99);
      fsz = (r < 40) ? 64'd0 : (r < 70) ? 64'({$urandom, $urandom}) & 64'(OFFSET_MAX)
                                        : 64'($urandom);
      case (ph)
        0: set_config(64'd65536, 64'd16, 64'd0);
        1: set_config(64'd1, 64'd1, 64'(OFFSET_MAX));
        2: set_config(64'h1FF_FFFF, 64'hFFFF, 64'd0);
        3: set_config(64'd0, 64'd0, fsz);
        4: set_config(64'd16777216, 64'd2, 64'($urandom));
        default: set_config(($urandom_range(0, 99) < 60) ? 64'($urandom_range(1, 8192))
                                                          : 64'($urandom & 32'h1FF_FFFF),
                            ($urandom_range(0, 99) < 70) ? 64'($urandom_range(1, 12))
                                                         : 64'($urandom & 32'hFFFF),
                            fsz);
      endcase
      tx_random = (ph != 4);
      rx_random = (ph != 4);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 60)      send_run_list($urandom_range(1, 6));
        else if (r < 95) send_run_list($urandom_range(7, 30));
        else             send_run_list($urandom_range(31, 120));
      end
      await_quiet();
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_chan.valid       = 1'b0;
    in_chan.block_index = '0;
    in_chan.last_block  = 1'b0;
    out_chan.ready      = 1'b0;
    run_head            = '0;
    run_tail            = '0;
    run_count           = '0;
    run_active          = 1'b0;
    hold_request        = 0;
    rx_left             = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_settings();
    test_zero_registers();
    test_file_end_clip();
    test_wide_values();
    test_backpressure();
    test_random_lists();

    if (pending_spans.size() != 0) begin
      $display("%0d ranges never arrived", pending_spans.size());
      mismatches++;
    end
    $display("sent %0d block indices over %0d register writes, checked %0d byte ranges",
             items_sent, cfg_writes, spans_seen);
    $display("covered run merging, fetch limits, saturation, file end clipping and stalls");
    if (mismatches == 0)
      $display("block_run_to_byte_range_unit: match");
    else
      $display("block_run_to_byte_range_unit: mismatch");
    $finish;
  end

endmodule
